### rtl/ihex_pkg.sv
`default_nettype none

package ihex_pkg;

    // result status codes
    typedef logic [2:0] status_t;
    localparam status_t ST_DATA      = 3'd0;
    localparam status_t ST_EXT_ADDR  = 3'd1;
    localparam status_t ST_OTHER     = 3'd2;
    localparam status_t ST_SHORT     = 3'd3;
    localparam status_t ST_CHECKSUM  = 3'd4;
    localparam status_t ST_TOO_LONG  = 3'd5;

    // record type codes
    localparam logic [7:0] TYPE_DATA    = 8'h00;
    localparam logic [7:0] TYPE_EXT_LIN = 8'h04;

    // character codes
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;

    // line length limits
    localparam logic [8:0] LEN_MAX     = 9'd511;
    localparam logic [8:0] REC_MIN_LEN = 9'd9;   // a record needs more than this
    localparam logic [8:0] EXT_MIN_LEN = 9'd14;  // type 4 needs more than this
    localparam logic [9:0] HDR_CHARS   = 10'd11; // colon, header, checksum

    // hex digit decode result
    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] ch);
        hex_digit_t d;
        d.ok  = 1'b1;
        d.nib = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            d.nib = 4'(ch - 8'h30);
        end
        else if (ch >= 8'h61 && ch <= 8'h66)
        begin
            d.nib = 4'(ch - 8'h57);
        end
        else if (ch >= 8'h41 && ch <= 8'h46)
        begin
            d.nib = 4'(ch - 8'h37);
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/ihex_ram.sv
`default_nettype none

module ihex_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/intel_hex_record_decoder_top.sv
`default_nettype none

// channel   direction  tdata                          tuser                  tlast
// s_axis    in         char_code[7:0]                 -                      final_char
// m_axis    out        byte_address, data_byte,       status, write_valid,   last_of_line
//                      extent_end                     bad_digit
//
// one character is taken per cycle while a line is being gathered
// after the end of a line the decoder classifies the record in S_FIN;
// a data record then passes through S_RD for the first buffer read and S_WR for the bytes,
// since the read port of the record buffer is registered
// rst_n clears all line state, the extended base and the extent; no clearing pass
// input is held off from end of line until the last item of that line is loaded or the line is dropped;
// a stalled output holds its item while the next one waits in the buffer read path

module intel_hex_record_decoder_top
    import ihex_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // char_code[7:0]
    input  wire logic        s_axis_tlast,   // final_char

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [79:0] m_axis_tdata,   // byte_address[31:0], data_byte[39:32],
                                             // extent_end[72:40], zero pad[79:73]
    output logic      [4:0]  m_axis_tuser,   // status[2:0], write_valid[3], bad_digit[4]
    output logic             m_axis_tlast    // last_of_line
);

    localparam int AW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
    localparam logic [7:0] MAX_B = 8'(MAX_RECORD_BYTES);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;  // gathering characters
    localparam logic [1:0] S_FIN  = 2'd1;  // classify finished line
    localparam logic [1:0] S_RD   = 2'd2;  // first buffer read
    localparam logic [1:0] S_WR   = 2'd3;  // emit byte writes

    logic [1:0]  state_reg, state_next;

    // line state
    logic [8:0]  len_reg, len_next;
    logic        is_rec_reg, is_rec_next;
    logic [3:0]  pend_reg, pend_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [15:0] offset_reg, offset_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] ext_cand_reg, ext_cand_next;
    logic        dig_err_reg, dig_err_next;
    logic        cnt_bad_reg, cnt_bad_next;
    logic        ext_bad_reg, ext_bad_next;

    // persistent state
    logic [15:0] ext_base_reg, ext_base_next;
    logic [32:0] mark_reg, mark_next;

    // emission
    logic [AW-1:0] idx_reg, idx_next;
    logic [31:0]   base_reg, base_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    status_t     o_status_reg, o_status_next;
    logic        o_wv_reg, o_wv_next;
    logic [31:0] o_addr_reg, o_addr_next;
    logic [7:0]  o_data_reg, o_data_next;
    logic [32:0] o_ext_reg, o_ext_next;
    logic        o_bad_reg, o_bad_next;
    logic        o_last_reg, o_last_next;

    // buffer ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    ihex_ram #(
        .WIDTH (8),
        .DEPTH (MAX_RECORD_BYTES)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, o_ext_reg, o_data_reg, o_addr_reg};
    assign m_axis_tuser  = {o_bad_reg, o_wv_reg, o_status_reg};
    assign m_axis_tlast  = o_last_reg;

    // character decode
    logic        accept;
    hex_digit_t  dig;
    logic [7:0]  pair;
    logic [7:0]  b_idx;
    logic [7:0]  d_idx;
    logic [9:0]  dig_lim;

    // line classification
    logic        out_free;
    logic        line_ok;
    logic        too_short;
    logic        line_bad;
    logic [31:0] lin_base;
    logic [32:0] rec_end;
    logic [32:0] mark_upd;
    logic        last_byte;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign dig      = hex_decode(s_axis_tdata);
    assign pair     = {pend_reg, dig.nib};
    assign b_idx    = len_reg[8:1] - 8'd1;         // byte index of an even position
    assign d_idx    = b_idx - 8'd4;                // data byte index
    assign dig_lim  = {1'b0, cnt_reg, 1'b0} + 10'd10;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign line_ok   = is_rec_reg && (len_reg > REC_MIN_LEN);
    assign too_short = {1'b0, len_reg} < ({1'b0, cnt_reg, 1'b0} + HDR_CHARS);
    assign line_bad  = cnt_bad_reg || dig_err_reg;
    assign lin_base  = {ext_base_reg, 16'h0000} + {16'h0000, offset_reg};
    assign rec_end   = {1'b0, ext_base_reg, 16'h0000} + {17'd0, offset_reg}
                       + {25'd0, cnt_reg};
    assign mark_upd  = (rec_end > mark_reg) ? rec_end : mark_reg;
    assign last_byte = (idx_reg == AW'(cnt_reg - 8'd1));

    always_comb
    begin
        logic clear_line;
        logic load;

        clear_line     = 1'b0;
        load           = 1'b0;
        state_next     = state_reg;
        len_next       = len_reg;
        is_rec_next    = is_rec_reg;
        pend_next      = pend_reg;
        cnt_next       = cnt_reg;
        offset_next    = offset_reg;
        type_next      = type_reg;
        sum_next       = sum_reg;
        ext_cand_next  = ext_cand_reg;
        dig_err_next   = dig_err_reg;
        cnt_bad_next   = cnt_bad_reg;
        ext_bad_next   = ext_bad_reg;
        ext_base_next  = ext_base_reg;
        mark_next      = mark_reg;
        idx_next       = idx_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg;
        o_status_next  = o_status_reg;
        o_wv_next      = o_wv_reg;
        o_addr_next    = o_addr_reg;
        o_data_next    = o_data_reg;
        o_ext_next     = o_ext_reg;
        o_bad_next     = o_bad_reg;
        o_last_next    = o_last_reg;
        wr_en          = 1'b0;
        wr_addr        = d_idx[AW-1:0];
        wr_data        = pair;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (len_reg < LEN_MAX)
                    begin
                        len_next = len_reg + 9'd1;
                        if (len_reg == 9'd0)
                        begin
                            is_rec_next = (s_axis_tdata == CH_COLON);
                        end
                        else if (is_rec_reg)
                        begin
                            if (len_reg <= 9'd2)
                            begin
                                if (!dig.ok)
                                begin
                                    cnt_bad_next = 1'b1;
                                end
                            end
                            else if ({1'b0, len_reg} <= dig_lim)
                            begin
                                if (!dig.ok)
                                begin
                                    dig_err_next = 1'b1;
                                end
                            end
                            // extended address digits
                            if (len_reg >= 9'd9 && len_reg <= 9'd12
                                && type_reg == TYPE_EXT_LIN)
                            begin
                                if (!dig.ok)
                                begin
                                    ext_bad_next = 1'b1;
                                end
                                ext_cand_next = {ext_cand_reg[11:0], dig.nib};
                            end
                            if (len_reg[0])
                            begin
                                pend_next = dig.nib;
                            end
                            else
                            begin
                                case (b_idx)
                                    8'd0:    cnt_next = pair;
                                    8'd1:    offset_next = {pair, 8'h00};
                                    8'd2:    offset_next = {offset_reg[15:8], pair};
                                    8'd3:    type_next = pair;
                                    default:
                                    begin
                                        if (d_idx < cnt_reg && d_idx < MAX_B)
                                        begin
                                            wr_en = 1'b1;
                                        end
                                    end
                                endcase
                                if ({1'b0, b_idx} <= ({1'b0, cnt_reg} + 9'd4))
                                begin
                                    sum_next = sum_reg + pair;
                                end
                            end
                        end
                    end
                    if (s_axis_tdata == CH_NEWLINE || s_axis_tlast)
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_FIN:
            begin
                if (!line_ok)
                begin
                    clear_line = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!too_short && sum_reg == 8'h00 && cnt_reg <= MAX_B
                         && type_reg == TYPE_DATA && cnt_reg != 8'd0)
                begin
                    // good data record with bytes: stream them out of the buffer
                    mark_next  = mark_upd;
                    base_next  = lin_base;
                    idx_next   = '0;
                    state_next = S_RD;
                end
                else if (out_free)
                begin
                    load          = 1'b1;
                    o_wv_next     = 1'b0;
                    o_addr_next   = 32'd0;
                    o_data_next   = 8'd0;
                    o_ext_next    = mark_reg;
                    o_bad_next    = line_bad;
                    o_last_next   = 1'b1;
                    if (too_short)
                    begin
                        o_status_next = ST_SHORT;
                        o_bad_next    = cnt_bad_reg;
                    end
                    else if (sum_reg != 8'h00)
                    begin
                        o_status_next = ST_CHECKSUM;
                    end
                    else if (cnt_reg > MAX_B)
                    begin
                        o_status_next = ST_TOO_LONG;
                    end
                    else if (type_reg == TYPE_DATA)
                    begin
                        // empty data record still moves the extent
                        o_status_next = ST_DATA;
                        mark_next     = mark_upd;
                        o_ext_next    = mark_upd;
                    end
                    else if (type_reg == TYPE_EXT_LIN && len_reg > EXT_MIN_LEN)
                    begin
                        o_status_next = ST_EXT_ADDR;
                        ext_base_next = ext_cand_reg;
                        o_bad_next    = line_bad || ext_bad_reg;
                    end
                    else
                    begin
                        o_status_next = ST_OTHER;
                    end
                    clear_line = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_WR;
            end

            S_WR:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    o_status_next = ST_DATA;
                    o_wv_next     = 1'b1;
                    o_addr_next   = base_reg + 32'(idx_reg);
                    o_data_next   = rd_data;
                    o_ext_next    = mark_reg;
                    o_bad_next    = line_bad;
                    o_last_next   = last_byte;
                    if (last_byte)
                    begin
                        clear_line = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // prefetch the next byte while this one goes out
                        idx_next = idx_reg + AW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + AW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end

        if (clear_line)
        begin
            len_next      = 9'd0;
            is_rec_next   = 1'b0;
            pend_next     = 4'd0;
            cnt_next      = 8'd0;
            offset_next   = 16'd0;
            type_next     = 8'd0;
            sum_next      = 8'd0;
            ext_cand_next = 16'd0;
            dig_err_next  = 1'b0;
            cnt_bad_next  = 1'b0;
            ext_bad_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= 9'd0;
            is_rec_reg    <= 1'b0;
            pend_reg      <= 4'd0;
            cnt_reg       <= 8'd0;
            offset_reg    <= 16'd0;
            type_reg      <= 8'd0;
            sum_reg       <= 8'd0;
            ext_cand_reg  <= 16'd0;
            dig_err_reg   <= 1'b0;
            cnt_bad_reg   <= 1'b0;
            ext_bad_reg   <= 1'b0;
            ext_base_reg  <= 16'd0;
            mark_reg      <= 33'd0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            is_rec_reg    <= is_rec_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            offset_reg    <= offset_next;
            type_reg      <= type_next;
            sum_reg       <= sum_next;
            ext_cand_reg  <= ext_cand_next;
            dig_err_reg   <= dig_err_next;
            cnt_bad_reg   <= cnt_bad_next;
            ext_bad_reg   <= ext_bad_next;
            ext_base_reg  <= ext_base_next;
            mark_reg      <= mark_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        o_status_reg <= o_status_next;
        o_wv_reg     <= o_wv_next;
        o_addr_reg   <= o_addr_next;
        o_data_reg   <= o_data_next;
        o_ext_reg    <= o_ext_next;
        o_bad_reg    <= o_bad_next;
        o_last_reg   <= o_last_next;
    end

endmodule

`default_nettype wire

### tb/sv/intel_hex_record_decoder_top_tb.sv
`default_nettype none

module intel_hex_record_decoder_top_tb;
    import ihex_pkg::*;

    localparam int MAX_BYTES    = 32;
    localparam int IDLE_PCT     = 18;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_CHARS   = 130;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_CR  = 8'h0d;

    // one decoded result, fields gathered from the output tdata, tuser and tlast
    typedef struct packed {
        status_t     status;
        logic        wr;
        logic [31:0] addr;
        logic [7:0]  data;
        logic [32:0] top;
        logic        bad;
        logic        last;
    } decoded_t;

    // hand-written outcome of a directed line, overrides the computed one
    typedef struct packed {
        logic    on;
        logic    silent;
        status_t st;
        logic    bad;
    } typed_t;

    typedef enum {ROW_TEXT, ROW_RECORD, ROW_LONG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        string       text;
        int unsigned count;
        logic        fin;
        typed_t      tag;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [4:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // travels with each character so the typed outcome lines up with it
    typed_t      s_tag = '0;

    bit          calm = 1'b0;
    int          cycle_no = 0;
    int          mismatches = 0;
    int          chars_sent = 0;

    decoded_t    decoded_q[$];
    logic [7:0]  line_chars[$];
    row_t        rows[$];

    // mirror of the decoder state
    int unsigned line_len = 0;
    int unsigned cnt = 0;
    logic        is_rec = 1'b0;
    logic        dig_err = 1'b0;
    logic        cnt_bad = 1'b0;
    logic        ext_bad = 1'b0;
    logic [3:0]  hi_nib = 4'd0;
    logic [15:0] offs = 16'h0;
    logic [15:0] ext_cand = 16'h0;
    logic [15:0] ext_base = 16'h0;
    logic [7:0]  rtype = 8'h00;
    logic [7:0]  sum = 8'h00;
    logic [32:0] extent = 33'h0;
    logic [7:0]  rec_bytes [MAX_BYTES];

    intel_hex_record_decoder_top #(
        .MAX_RECORD_BYTES(MAX_BYTES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // sink side back-pressure
    always @(posedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // take one character, append any results of a finished line
    function automatic void decode_char(logic [7:0] ch, logic fin, typed_t tag);
        int unsigned p;
        int unsigned b;
        logic [3:0]  nib;
        logic        ok;
        logic [7:0]  v;
        logic        bad;
        logic        single;
        status_t     st;
        logic [32:0] rec_end;
        decoded_t    r;
        decoded_t    line_out[$];
        p = line_len;
        if (line_len < LEN_MAX)
        begin
            line_len++;
            if (p == 0)
            begin
                is_rec = (ch == CH_COLON);
            end
            else if (is_rec)
            begin
                ok  = 1'b1;
                nib = 4'd0;
                if (ch >= 8'h30 && ch <= 8'h39)
                    nib = 4'(ch - 8'h30);
                else if (ch >= 8'h61 && ch <= 8'h66)
                    nib = 4'(ch - 8'h61 + 8'd10);
                else if (ch >= 8'h41 && ch <= 8'h46)
                    nib = 4'(ch - 8'h41 + 8'd10);
                else
                    ok = 1'b0;
                // count digits flag separately, they matter for too-short lines
                if (p <= 2)
                begin
                    if (!ok)
                        cnt_bad = 1'b1;
                end
                else if (p <= 2 * cnt + 10)
                begin
                    if (!ok)
                        dig_err = 1'b1;
                end
                if (p >= 9 && p <= 12 && rtype == TYPE_EXT_LIN)
                begin
                    if (!ok)
                        ext_bad = 1'b1;
                    ext_cand = {ext_cand[11:0], nib};
                end
                if (p[0])
                begin
                    hi_nib = nib;
                end
                else
                begin
                    v = {hi_nib, nib};
                    b = (p - 1) >> 1;
                    if (b == 0)
                        cnt = v;
                    else if (b == 1)
                        offs = {v, 8'h00};
                    else if (b == 2)
                        offs = offs | {8'h00, v};
                    else if (b == 3)
                        rtype = v;
                    else if (b - 4 < cnt && b - 4 < MAX_BYTES)
                        rec_bytes[b - 4] = v;
                    if (b <= cnt + 4)
                        sum = sum + v;
                end
            end
        end
        if (ch != CH_NEWLINE && !fin)
            return;

        bad    = cnt_bad | dig_err;
        single = 1'b1;
        st     = ST_OTHER;
        if (!is_rec || line_len <= REC_MIN_LEN)
        begin
            single = 1'b0;
        end
        else if (line_len < 2 * cnt + HDR_CHARS)
        begin
            st  = ST_SHORT;
            bad = cnt_bad;
        end
        else if (sum != 8'h00)
        begin
            st = ST_CHECKSUM;
        end
        else if (cnt > MAX_BYTES)
        begin
            st = ST_TOO_LONG;
        end
        else if (rtype == TYPE_DATA)
        begin
            rec_end = 33'({ext_base, 16'h0}) + 33'(offs) + 33'(cnt);
            if (rec_end > extent)
                extent = rec_end;
            st = ST_DATA;
            if (cnt != 0)
            begin
                single = 1'b0;
                for (int unsigned i = 0; i < cnt; i++)
                begin
                    r        = '0;
                    r.status = ST_DATA;
                    r.wr     = 1'b1;
                    r.addr   = {ext_base, 16'h0} + 32'(offs) + 32'(i);
                    r.data   = rec_bytes[i];
                    r.top    = extent;
                    r.bad    = bad;
                    r.last   = (i + 1 == cnt);
                    line_out.push_back(r);
                end
            end
        end
        else if (rtype == TYPE_EXT_LIN && line_len > EXT_MIN_LEN)
        begin
            ext_base = ext_cand;
            st       = ST_EXT_ADDR;
            bad      = bad | ext_bad;
        end

        if (tag.on)
        begin
            line_out.delete();
            single = !tag.silent;
            st     = tag.st;
            bad    = tag.bad;
        end
        if (single)
        begin
            r        = '0;
            r.status = st;
            r.top    = extent;
            r.bad    = bad;
            r.last   = 1'b1;
            line_out.push_back(r);
        end
        foreach (line_out[j])
            decoded_q.push_back(line_out[j]);

        line_len = 0;
        is_rec   = 1'b0;
        hi_nib   = 4'd0;
        cnt      = 0;
        offs     = 16'h0;
        rtype    = 8'h00;
        sum      = 8'h00;
        ext_cand = 16'h0;
        dig_err  = 1'b0;
        cnt_bad  = 1'b0;
        ext_bad  = 1'b0;
    endfunction

    function automatic string show(decoded_t r);
        return $sformatf("st=%0d wr=%0b addr=%08h data=%02h top=%09h bad=%0b last=%0b",
                         r.status, r.wr, r.addr, r.data, r.top, r.bad, r.last);
    endfunction

    // predict on accepted characters, then check the accepted result
    always @(posedge clk)
    begin : check_blk
        decoded_t seen;
        decoded_t want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            decode_char(s_axis_tdata, s_axis_tlast, s_tag);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = {m_axis_tuser[2:0], m_axis_tuser[3], m_axis_tdata[31:0],
                    m_axis_tdata[39:32], m_axis_tdata[72:40], m_axis_tuser[4],
                    m_axis_tlast};
            if (decoded_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %s", show(seen));
            end
            else
            begin
                want = decoded_q.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %s / got %s", show(want), show(seen));
                end
            end
        end
    end

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_chars.push_back(s[i]);
    endtask

    task automatic put_hex(logic [7:0] b);
        string s;
        s = $urandom_range(0, 1) ? $sformatf("%02x", b) : $sformatf("%02X", b);
        line_chars.push_back(s[0]);
        line_chars.push_back(s[1]);
    endtask

    // well-formed record with a good checksum, random data bytes (type 4 carries ext first)
    task automatic build_record(int unsigned count, logic [15:0] at, logic [7:0] kind,
                                logic [15:0] ext);
        logic [7:0] rec_q[$];
        logic [7:0] csum;
        rec_q.push_back(8'(count));
        rec_q.push_back(at[15:8]);
        rec_q.push_back(at[7:0]);
        rec_q.push_back(kind);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (kind == TYPE_EXT_LIN && i < 2)
                rec_q.push_back(i == 0 ? ext[15:8] : ext[7:0]);
            else
                rec_q.push_back(8'($urandom_range(0, 255)));
        end
        csum = 8'h00;
        foreach (rec_q[i])
            csum = csum + rec_q[i];
        rec_q.push_back(8'h00 - csum);
        line_chars.push_back(CH_COLON);
        foreach (rec_q[i])
            put_hex(rec_q[i]);
        line_chars.push_back(CH_NEWLINE);
    endtask

    task automatic send_line(typed_t tag, logic fin_last);
        for (int i = 0; i < line_chars.size(); i++)
        begin
            while (!calm && $urandom_range(0, 99) < IDLE_PCT)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= line_chars[i];
            s_axis_tlast  <= fin_last && (i == line_chars.size() - 1);
            s_tag         <= tag;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            chars_sent++;
        end
        line_chars.delete();
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(row_kind_t kind, string text, int unsigned count, logic fin,
                           logic on, logic silent, status_t st, logic bad);
        row_t r;
        r.kind   = kind;
        r.text   = text;
        r.count  = count;
        r.fin    = fin;
        r.tag    = '{on: on, silent: silent, st: st, bad: bad};
        rows.push_back(r);
    endtask

    initial
    begin : stim
        int          chars_mark;
        int          line_no;
        int unsigned pick;
        int unsigned count;
        logic [7:0]  kind;
        logic [15:0] ext;
        logic [7:0]  c;
        logic        fin_last;
        typed_t      plain;

        plain = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines; typed rows carry their outcome, the rest are predicted
        add_row(ROW_TEXT,   ":00000001FF\n",         0, 0, 1, 0, ST_OTHER,    0);
        add_row(ROW_TEXT,   "hello\n",               0, 0, 1, 1, ST_OTHER,    0);
        add_row(ROW_TEXT,   ":0000000\n",            0, 0, 1, 1, ST_OTHER,    0);
        add_row(ROW_TEXT,   ":00000000\n",           0, 0, 1, 0, ST_SHORT,    0);
        add_row(ROW_TEXT,   ":10000000\n",           0, 0, 1, 0, ST_SHORT,    0);
        add_row(ROW_TEXT,   ":G0000000\n",           0, 0, 1, 0, ST_SHORT,    1);
        // bad data digits do not count on a too-short line
        add_row(ROW_TEXT,   ":01000000ZZ\n",         0, 0, 1, 0, ST_SHORT,    0);
        add_row(ROW_TEXT,   ":0100000055AB\n",       0, 0, 1, 0, ST_CHECKSUM, 0);
        add_row(ROW_TEXT,   ":02000000FF00FF\n",     0, 0, 0, 0, ST_DATA,     0);
        add_row(ROW_TEXT,   ":02000004FFFFFC\n",     0, 0, 1, 0, ST_EXT_ADDR, 0);
        // addresses wrap past the top, extent goes beyond 32 bits
        add_row(ROW_TEXT,   ":04FFFE001122334455\n", 0, 0, 0, 0, ST_DATA,     0);
        add_row(ROW_TEXT,   ":020000040000FA\n",     0, 0, 1, 0, ST_EXT_ADDR, 0);
        // type 4 too short to carry an address
        add_row(ROW_TEXT,   ":00000004FC\n",         0, 0, 1, 0, ST_OTHER,    0);
        add_row(ROW_TEXT,   ":02000004G000FA\n",     0, 0, 1, 0, ST_EXT_ADDR, 1);
        add_row(ROW_RECORD, "",                     33, 0, 1, 0, ST_TOO_LONG, 0);
        add_row(ROW_RECORD, "",                     32, 0, 0, 0, ST_DATA,     0);
        add_row(ROW_TEXT,   ":01000000ZZFF\n",       0, 0, 0, 0, ST_DATA,     0);
        add_row(ROW_TEXT,   ":00123400BA\n",         0, 0, 0, 0, ST_DATA,     0);
        add_row(ROW_TEXT,   ":01001000ab44\n",       0, 0, 0, 0, ST_DATA,     0);
        add_row(ROW_TEXT,   ":00000001FF\r\n",       0, 0, 1, 0, ST_OTHER,    0);
        // line far past the length counter limit
        add_row(ROW_LONG,   ":0000AB0055",           0, 0, 0, 0, ST_DATA,     0);
        // end of file mark closes the line without a newline
        add_row(ROW_TEXT,   ":00000001FF",           0, 1, 1, 0, ST_OTHER,    0);

        foreach (rows[k])
        begin
            case (rows[k].kind)
                ROW_TEXT:
                    put_text(rows[k].text);
                ROW_RECORD:
                    build_record(rows[k].count, 16'($urandom), TYPE_DATA, 16'h0);
                default:
                begin
                    put_text(rows[k].text);
                    repeat (520) line_chars.push_back("q");
                    line_chars.push_back(CH_NEWLINE);
                end
            endcase
            send_line(rows[k].tag, rows[k].fin);
        end
        hold_until_drained();

        // random lines: mostly records with random content, some broken, some noise
        chars_mark = chars_sent;
        line_no = 0;
        while (chars_sent < chars_mark + RAND_CHARS)
        begin
            // a stretch with no idling on either side
            calm = (line_no == 1)
                   || (chars_sent >= chars_mark + 20 && chars_sent < chars_mark + 90);
            pick = $urandom_range(0, 99);
            if (pick < 77)
            begin
                if (pick < 55)
                begin
                    count = $urandom_range(0, 99);
                    count = count < 70 ? $urandom_range(0, 8) :
                            count < 95 ? $urandom_range(9, 32) : $urandom_range(33, 48);
                    kind = TYPE_DATA;
                end
                else if (pick < 67)
                begin
                    count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 2;
                    kind = TYPE_EXT_LIN;
                end
                else
                begin
                    count = $urandom_range(0, 4);
                    kind = 8'($urandom_range(0, 255));
                end
                ext = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
                build_record(count, 16'($urandom), kind, ext);
                // corrupt one character
                if ($urandom_range(0, 99) < 12)
                    line_chars[$urandom_range(1, line_chars.size() - 2)] =
                        8'($urandom_range(0, 255));
                // cut the line short
                if ($urandom_range(0, 99) < 8)
                begin
                    repeat ($urandom_range(2, 7)) void'(line_chars.pop_back());
                    line_chars.push_back(CH_NEWLINE);
                end
            end
            else
            begin
                if ($urandom_range(0, 1))
                    line_chars.push_back(CH_COLON);
                repeat ($urandom_range(0, 24))
                begin
                    case ($urandom_range(0, 7))
                        0:       c = CH_NUL;
                        1:       c = CH_CR;
                        2:       c = 8'($urandom_range(128, 255));
                        default: c = 8'($urandom_range(0, 255));
                    endcase
                    line_chars.push_back(c);
                end
                line_chars.push_back(CH_NEWLINE);
            end
            fin_last = 1'b0;
            if ($urandom_range(0, 99) < 6 && line_chars.size() > 1)
            begin
                void'(line_chars.pop_back());
                fin_last = 1'b1;
            end
            send_line(plain, fin_last);
            if (line_no == 3)
                hold_until_drained();
            line_no++;
        end
        calm = 1'b0;

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
